FILE: src/gimbal_scale_and_arm_logic_macros.svh
// Assertion macros for the checker of the gimbal scaling block.
`ifndef GIMBAL_SCALE_AND_ARM_LOGIC_MACROS_SVH
`define GIMBAL_SCALE_AND_ARM_LOGIC_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GSAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GSAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gsal_pkg.sv
// Types and constants shared by the gimbal scaling and arming block.
`default_nettype none
package gsal_pkg;

  localparam int RAW_W        = 10;
  localparam int SCL_W        = 8;
  localparam int NUM_CH       = 4;
  localparam int DVD_W        = RAW_W + SCL_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CENTER_CNT_W = 10;
  localparam int CAL_CNT_W    = 9;

  // channel slots
  localparam int CH_THROTTLE = 0;
  localparam int CH_YAW      = 1;
  localparam int CH_ROLL     = 2;
  localparam int CH_PITCH    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_HIGH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH    = 3'd7;

  localparam logic [SCL_W-1:0] ARM_THR_BELOW   = 8'd5;
  localparam logic [SCL_W-1:0] ARM_STICK_ABOVE = 8'd250;
  localparam logic [SCL_W-1:0] SCALE_TOP       = 8'd255;

  // one division job: quotient is dvd / dvs, always below 256
  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [RAW_W-1:0] dvs;
  } div_job_t;

  typedef struct packed {
    logic left;
    logic right;
    logic center;
    logic down;
    logic aux_two;
    logic ack;
  } btn_t;

  // classified item handed from front to back
  typedef struct packed {
    div_job_t [NUM_CH-1:0] job;
    btn_t                  btn;
  } work_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SCL_W-1:0] scaled;
    logic                         is_armed;
    logic                         save_request;
    logic                         calibrate_request;
  } result_t;

endpackage
`default_nettype wire

FILE: src/gsal_front.sv
// Front end: calibration registers, clamping and division job setup.
`default_nettype none
module gsal_front
  import gsal_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [RAW_W-1:0]             cfg_data,
  input  wire logic [NUM_CH-1:0][RAW_W-1:0] raw,
  input  wire btn_t                         btn,
  output work_t                             work
);

  logic [NUM_CH-1:0][RAW_W-1:0] lo_r;
  logic [NUM_CH-1:0][RAW_W-1:0] hi_r;

  logic [NUM_CH-1:0][RAW_W-1:0] clamp;
  logic [NUM_CH-1:0][RAW_W-1:0] ofs;
  logic [NUM_CH-1:0][RAW_W-1:0] span;
  logic [NUM_CH-1:0][DVD_W-1:0] prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THROTTLE_LOW:  lo_r[CH_THROTTLE] <= cfg_data;
        REG_THROTTLE_HIGH: hi_r[CH_THROTTLE] <= cfg_data;
        REG_YAW_LOW:       lo_r[CH_YAW]      <= cfg_data;
        REG_YAW_HIGH:      hi_r[CH_YAW]      <= cfg_data;
        REG_ROLL_LOW:      lo_r[CH_ROLL]     <= cfg_data;
        REG_ROLL_HIGH:     hi_r[CH_ROLL]     <= cfg_data;
        REG_PITCH_LOW:     lo_r[CH_PITCH]    <= cfg_data;
        REG_PITCH_HIGH:    hi_r[CH_PITCH]    <= cfg_data;
      endcase
    end
  end

  // Degenerate bounds are folded into trivial jobs (0/1 or 255/1) so the
  // back end always runs the same divide.
  always_comb begin
    work.btn = btn;
    for (int c = 0; c < NUM_CH; c++) begin
      if (raw[c] < lo_r[c]) begin
        clamp[c] = lo_r[c];
      end else if (raw[c] > hi_r[c]) begin
        clamp[c] = hi_r[c];
      end else begin
        clamp[c] = raw[c];
      end
      ofs[c]  = clamp[c] - lo_r[c];
      span[c] = hi_r[c] - lo_r[c];
      prod[c] = {ofs[c], {SCL_W{1'b0}}} - {{SCL_W{1'b0}}, ofs[c]};   // ofs * 255

      priority if (lo_r[c] == hi_r[c]) begin
        work.job[c].dvd = '0;
        work.job[c].dvs = RAW_W'(1);
      end else if (lo_r[c] > hi_r[c]) begin
        work.job[c].dvd = (clamp[c] == lo_r[c]) ? '0 : DVD_W'(SCALE_TOP);
        work.job[c].dvs = RAW_W'(1);
      end else begin
        work.job[c].dvd = prod[c];
        work.job[c].dvs = span[c];
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/gsal_queue.sv
// Small FIFO of classified items between front and back end.
`default_nettype none
module gsal_queue
  import gsal_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t wr_data,
  output logic       full,
  input  wire logic  pop,
  output work_t      rd_data,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/gsal_back.sv
// Back end: shared bit-serial divider, arm/hold state and result register.
`default_nettype none
module gsal_back
  import gsal_pkg::*;
#(
  parameter int SAVE_HOLD_TICKS = 800,
  parameter int CAL_HOLD_TICKS  = 300
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire work_t q_data,
  output logic       out_empty,
  input  wire logic  out_pop,
  output result_t    res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam int BIT_W = $clog2(SCL_W);
  localparam int CH_W  = $clog2(NUM_CH);

  logic [1:0]                   st_r;
  logic [BIT_W-1:0]             bit_r;
  logic [CH_W-1:0]              ch_cnt_r;
  logic                         res_valid_r;
  logic                         armed_r;
  logic                         pend_r;
  logic [CENTER_CNT_W-1:0]      center_cnt_r;
  logic [CAL_CNT_W-1:0]         cal_cnt_r;

  div_job_t [NUM_CH-1:0]        job_r;
  btn_t                         btn_r;
  logic [RAW_W-1:0]             rem_r;
  logic [SCL_W-1:0]             quo_r;
  logic [NUM_CH-1:0][SCL_W-1:0] scl_r;
  result_t                      res_r;

  logic [SCL_W-1:0]             low_bits;
  logic [RAW_W:0]               trial;
  logic [RAW_W:0]               dvs_ext;
  logic                         qbit;
  logic [RAW_W-1:0]             rem_step;
  logic [SCL_W-1:0]             quo_step;
  logic                         ch_done;
  logic                         fin_go;

  logic                         arm_set;
  logic                         armed_nxt;
  logic                         pend_nxt;
  logic                         save_hit;
  logic                         cal_hit;
  logic [CENTER_CNT_W-1:0]      center_cnt_nxt;
  logic [CAL_CNT_W-1:0]         cal_cnt_nxt;
  logic [CENTER_CNT_W-1:0]      center_step;
  logic [CAL_CNT_W-1:0]         cal_step;

  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign out_empty = !res_valid_r;
  assign res       = res_r;
  assign fin_go    = (st_r == ST_FIN) && (!res_valid_r || out_pop);
  assign ch_done   = (st_r == ST_DIV) && (bit_r == '0);

  // restoring divide, one quotient bit per cycle; channel 0 is always current
  assign low_bits = job_r[0].dvd[SCL_W-1:0];
  assign trial    = {rem_r, low_bits[bit_r]};
  assign dvs_ext  = {1'b0, job_r[0].dvs};
  assign qbit     = (trial >= dvs_ext);
  assign rem_step = qbit ? RAW_W'(trial - dvs_ext) : trial[RAW_W-1:0];
  assign quo_step = {quo_r[SCL_W-2:0], qbit};

  // tick update: ack clear, arm, disarm, center hold, calibrate hold
  always_comb begin
    arm_set = (scl_r[CH_THROTTLE] < ARM_THR_BELOW) &&
              (scl_r[CH_YAW] > ARM_STICK_ABOVE) &&
              (scl_r[CH_ROLL] > ARM_STICK_ABOVE) &&
              (scl_r[CH_PITCH] > ARM_STICK_ABOVE);
    armed_nxt = (armed_r || arm_set) && !(btn_r.left && btn_r.right);

    center_step    = center_cnt_r + 1'b1;
    save_hit       = 1'b0;
    center_cnt_nxt = '0;
    if (btn_r.center) begin
      if (center_cnt_r < CENTER_CNT_W'(SAVE_HOLD_TICKS)) begin
        center_cnt_nxt = center_step;
        save_hit       = (center_step == CENTER_CNT_W'(SAVE_HOLD_TICKS));
      end else begin
        center_cnt_nxt = center_cnt_r;
      end
    end

    cal_step    = cal_cnt_r + 1'b1;
    cal_hit     = 1'b0;
    cal_cnt_nxt = '0;
    if (btn_r.down && btn_r.aux_two) begin
      if (!armed_nxt && cal_cnt_r < CAL_CNT_W'(CAL_HOLD_TICKS)) begin
        cal_cnt_nxt = cal_step;
        cal_hit     = (cal_step == CAL_CNT_W'(CAL_HOLD_TICKS));
      end else begin
        cal_cnt_nxt = cal_cnt_r;
      end
    end

    pend_nxt = (pend_r && !btn_r.ack) || cal_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      bit_r        <= '0;
      ch_cnt_r     <= '0;
      res_valid_r  <= 1'b0;
      armed_r      <= 1'b0;
      pend_r       <= 1'b0;
      center_cnt_r <= '0;
      cal_cnt_r    <= '0;
    end else begin
      if (fin_go) begin
        res_valid_r <= 1'b1;
      end else if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            bit_r    <= BIT_W'(SCL_W - 1);
            ch_cnt_r <= '0;
            st_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          bit_r <= bit_r - 1'b1;
          if (ch_done) begin
            ch_cnt_r <= ch_cnt_r + 1'b1;
            if (ch_cnt_r == CH_W'(NUM_CH - 1)) begin
              st_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            armed_r      <= armed_nxt;
            pend_r       <= pend_nxt;
            center_cnt_r <= center_cnt_nxt;
            cal_cnt_r    <= cal_cnt_nxt;
            st_r         <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data.job;
      btn_r <= q_data.btn;
      rem_r <= q_data.job[0].dvd[DVD_W-1:SCL_W];
    end else if (st_r == ST_DIV) begin
      quo_r <= quo_step;
      if (ch_done) begin
        // rotate the next channel into slot 0, shift finished quotient in
        job_r <= {job_r[0], job_r[NUM_CH-1:1]};
        scl_r <= {quo_step, scl_r[NUM_CH-1:1]};
        rem_r <= job_r[1].dvd[DVD_W-1:SCL_W];
      end else begin
        rem_r <= rem_step;
      end
    end
    if (fin_go) begin
      res_r.scaled            <= scl_r;
      res_r.is_armed          <= armed_nxt;
      res_r.save_request      <= save_hit;
      res_r.calibrate_request <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/gimbal_scale_and_arm_logic.sv
// Gimbal stick scaling and arming logic, top level.
// An accepted item passes the queue slot, a load step into the back end,
// 4 channels x 8 quotient bits of divide and an update step; the update
// waits while the result is not popped. The single shared divider takes a new item only after the last one is done.
// Reset (rst_n low, synchronous): queue and result emptied, disarmed, hold
// counters and calibrate flag cleared, bounds back to 0..1023.
`default_nettype none
module gimbal_scale_and_arm_logic
  import gsal_pkg::*;
#(
  parameter int SAVE_HOLD_TICKS = 800,
  parameter int CAL_HOLD_TICKS  = 300,
  parameter int QUEUE_DEPTH     = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [RAW_W-1:0]     in_throttle_raw,
  input  wire logic [RAW_W-1:0]     in_yaw_raw,
  input  wire logic [RAW_W-1:0]     in_roll_raw,
  input  wire logic [RAW_W-1:0]     in_pitch_raw,
  input  wire logic                 in_press_left,
  input  wire logic                 in_press_right,
  input  wire logic                 in_press_center,
  input  wire logic                 in_press_down,
  input  wire logic                 in_press_aux_two,
  input  wire logic                 in_calibrate_ack,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [SCL_W-1:0]          out_throttle_scaled,
  output logic [SCL_W-1:0]          out_yaw_scaled,
  output logic [SCL_W-1:0]          out_roll_scaled,
  output logic [SCL_W-1:0]          out_pitch_scaled,
  output logic                      out_is_armed,
  output logic                      out_save_request,
  output logic                      out_calibrate_request,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RAW_W-1:0]     cfg_data
);

  logic [NUM_CH-1:0][RAW_W-1:0] raw;
  btn_t                         btn;
  work_t                        fr_work;
  work_t                        q_data;
  logic                         q_empty;
  logic                         q_pop;
  result_t                      res;

  assign raw[CH_THROTTLE] = in_throttle_raw;
  assign raw[CH_YAW]      = in_yaw_raw;
  assign raw[CH_ROLL]     = in_roll_raw;
  assign raw[CH_PITCH]    = in_pitch_raw;

  assign btn.left    = in_press_left;
  assign btn.right   = in_press_right;
  assign btn.center  = in_press_center;
  assign btn.down    = in_press_down;
  assign btn.aux_two = in_press_aux_two;
  assign btn.ack     = in_calibrate_ack;

  gsal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raw       (raw),
    .btn       (btn),
    .work      (fr_work)
  );

  gsal_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (fr_work),
    .full    (in_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  gsal_back #(
    .SAVE_HOLD_TICKS (SAVE_HOLD_TICKS),
    .CAL_HOLD_TICKS  (CAL_HOLD_TICKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_throttle_scaled   = res.scaled[CH_THROTTLE];
  assign out_yaw_scaled        = res.scaled[CH_YAW];
  assign out_roll_scaled       = res.scaled[CH_ROLL];
  assign out_pitch_scaled      = res.scaled[CH_PITCH];
  assign out_is_armed          = res.is_armed;
  assign out_save_request      = res.save_request;
  assign out_calibrate_request = res.calibrate_request;

endmodule
`default_nettype wire

FILE: src/gsal_checker.sv
// Port-level checker for the gimbal scaling block, with its bind.
`default_nettype none
`include "gimbal_scale_and_arm_logic_macros.svh"
module gsal_checker
  import gsal_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_empty,
  input wire logic             out_pop,
  input wire logic [SCL_W-1:0] out_throttle_scaled,
  input wire logic [SCL_W-1:0] out_yaw_scaled,
  input wire logic [SCL_W-1:0] out_roll_scaled,
  input wire logic [SCL_W-1:0] out_pitch_scaled,
  input wire logic             out_is_armed,
  input wire logic             out_save_request,
  input wire logic             out_calibrate_request
);

  logic pop_ok;
  logic last_arm_r;
  logic last_save_r;
  logic last_cal_r;

  assign pop_ok = out_pop && !out_empty;

  // flags of the previous item taken; reset matches the block's reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_arm_r  <= 1'b0;
      last_save_r <= 1'b0;
      last_cal_r  <= 1'b0;
    end else if (pop_ok) begin
      last_arm_r  <= out_is_armed;
      last_save_r <= out_save_request;
      last_cal_r  <= out_calibrate_request;
    end
  end

  `GSAL_ASSERT_NXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_throttle_scaled) && $stable(out_is_armed) && $stable(out_save_request), "result changed while waiting")
  `GSAL_ASSERT_IMP(a_save_once, pop_ok && out_save_request, !last_save_r, "save request on two items in a row")
  `GSAL_ASSERT_IMP(a_arm_gesture, pop_ok && out_is_armed && !last_arm_r, out_throttle_scaled < ARM_THR_BELOW && out_yaw_scaled > ARM_STICK_ABOVE && out_roll_scaled > ARM_STICK_ABOVE && out_pitch_scaled > ARM_STICK_ABOVE, "armed without stick gesture")
  `GSAL_ASSERT_IMP(a_cal_disarmed, pop_ok && out_calibrate_request && !last_cal_r, !out_is_armed, "calibrate raised while armed")

endmodule

bind gimbal_scale_and_arm_logic gsal_checker u_gsal_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_empty             (out_empty),
  .out_pop               (out_pop),
  .out_throttle_scaled   (out_throttle_scaled),
  .out_yaw_scaled        (out_yaw_scaled),
  .out_roll_scaled       (out_roll_scaled),
  .out_pitch_scaled      (out_pitch_scaled),
  .out_is_armed          (out_is_armed),
  .out_save_request      (out_save_request),
  .out_calibrate_request (out_calibrate_request)
);
`default_nettype wire
